/* src/assert_macros.svh */
// Shared assertion forms, clocked on the rising edge and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

/* src/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // What every cell of one chain does in a cycle.
    typedef enum logic [1:0] {
        CMD_HOLD      = 2'd0,
        CMD_SHIFT_IN  = 2'd1,   // insert at cell 0, everything moves one up
        CMD_SHIFT_OUT = 2'd2,   // drop cell 0, everything moves one down
        CMD_APPEND    = 2'd3    // write the cell whose index equals the count
    } cmd_t;

    // Front chain keeps front at cell 0, back chain keeps back at cell 0.
    typedef struct packed {
        cmd_t front_cmd;
        cmd_t back_cmd;
    } chain_ctl_t;

endpackage

/* src/deq_req_if.sv */
`timescale 1ns / 1ps

interface deq_req_if;
    logic                                valid;
    logic                                ready;
    logic [deq_pkg::OP_W-1:0]            op;
    logic signed [deq_pkg::WORD_W-1:0]   value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

/* src/deq_rsp_if.sv */
`timescale 1ns / 1ps

interface deq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [deq_pkg::WORD_W-1:0]    front_value;
    logic signed [deq_pkg::WORD_W-1:0]    back_value;
    logic [deq_pkg::COUNT_W-1:0]          count;
    logic                                 empty_res;
    logic [deq_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output front_value, output back_value, output count,
                    output empty_res, output status, input ready);
    modport sink   (input valid, input front_value, input back_value, input count,
                    input empty_res, input status, output ready);
endinterface

/* src/deq_cell.sv */
`timescale 1ns / 1ps

module deq_cell #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                              clk,
    input  deq_pkg::cmd_t                     cmd,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  logic [DATA_WIDTH-1:0]             new_word,
    input  logic [DATA_WIDTH-1:0]             prev_word,
    input  logic [DATA_WIDTH-1:0]             next_word,
    output logic [DATA_WIDTH-1:0]             word
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_WIDTH-1:0] word_reg;
    logic [DATA_WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        case (cmd)
            deq_pkg::CMD_HOLD:      word_next = word_reg;
            deq_pkg::CMD_SHIFT_IN:  word_next = prev_word;
            deq_pkg::CMD_SHIFT_OUT: word_next = next_word;
            deq_pkg::CMD_APPEND:
            begin
                if (count == CNT_W'(IDX))
                    word_next = new_word;
            end
            default:                word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* src/deq_ctrl.sv */
`timescale 1ns / 1ps

module deq_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  deq_pkg::op_t                  op,
    output deq_pkg::chain_ctl_t           ctl,
    output logic [$clog2(DEPTH+1)-1:0]    count,
    output deq_pkg::status_t              status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    deq_pkg::status_t  status_reg;
    deq_pkg::status_t  status_next;
    logic              full;
    logic              empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        count_next    = count_reg;
        status_next   = status_reg;
        ctl.front_cmd = deq_pkg::CMD_HOLD;
        ctl.back_cmd  = deq_pkg::CMD_HOLD;
        if (accept)
        begin
            status_next = deq_pkg::ST_OK;
            case (op)
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (full)
                        status_next = deq_pkg::ST_OVERFLOW;
                    else
                    begin
                        ctl.front_cmd = deq_pkg::CMD_SHIFT_IN;
                        ctl.back_cmd  = deq_pkg::CMD_APPEND;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (full)
                        status_next = deq_pkg::ST_OVERFLOW;
                    else
                    begin
                        ctl.front_cmd = deq_pkg::CMD_APPEND;
                        ctl.back_cmd  = deq_pkg::CMD_SHIFT_IN;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (empty)
                        status_next = deq_pkg::ST_UNDERFLOW;
                    else
                    begin
                        // back chain just loses its last valid cell
                        ctl.front_cmd = deq_pkg::CMD_SHIFT_OUT;
                        count_next    = count_reg - CNT_W'(1);
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (empty)
                        status_next = deq_pkg::ST_UNDERFLOW;
                    else
                    begin
                        ctl.back_cmd = deq_pkg::CMD_SHIFT_OUT;
                        count_next   = count_reg - CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= deq_pkg::ST_OK;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;

endmodule

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps
// Latency: a result is valid the cycle after its word is accepted.
// Throughput: one word per cycle while rsp.ready stays high; a held result
// blocks the next word. Each operation is one broadcast command to two rows
// of DEPTH cells (front-ordered and back-ordered copies).
// Reset (async, active low) empties the queue and clears the result valid;
// cell contents are not reset.

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    deq_req_if.sink     req,
    deq_rsp_if.source   rsp
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = deq_pkg::WORD_W;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accept;
    deq_pkg::chain_ctl_t    ctl;
    logic [CNT_W-1:0]       count;
    deq_pkg::status_t       status;
    logic [DATA_WIDTH-1:0]  new_word;
    logic [DATA_WIDTH-1:0]  front_words [DEPTH];
    logic [DATA_WIDTH-1:0]  back_words  [DEPTH];
    logic [WORD_W-1:0]      front_w;
    logic [WORD_W-1:0]      back_w;
    logic                   empty;

    // results are taken from the cells directly, so a new word may enter
    // exactly when the pending result leaves
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign out_valid_next = accept || (out_valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (deq_pkg::op_t'(req.op)),
        .ctl    (ctl),
        .count  (count),
        .status (status)
    );

    generate
        if (DATA_WIDTH <= WORD_W)
        begin : g_in_narrow
            assign new_word = req.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_in_wide
            assign new_word = {{(DATA_WIDTH-WORD_W){req.value[WORD_W-1]}}, req.value};
        end
    endgenerate

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cells
            logic [DATA_WIDTH-1:0] f_prev;
            logic [DATA_WIDTH-1:0] f_next;
            logic [DATA_WIDTH-1:0] b_prev;
            logic [DATA_WIDTH-1:0] b_next;

            if (i == 0)
            begin : g_first
                assign f_prev = new_word;
                assign b_prev = new_word;
            end
            else
            begin : g_mid
                assign f_prev = front_words[i-1];
                assign b_prev = back_words[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign f_next = front_words[i];
                assign b_next = back_words[i];
            end
            else
            begin : g_inner
                assign f_next = front_words[i+1];
                assign b_next = back_words[i+1];
            end

            deq_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (i)
            ) u_front_cell (
                .clk       (clk),
                .cmd       (ctl.front_cmd),
                .count     (count),
                .new_word  (new_word),
                .prev_word (f_prev),
                .next_word (f_next),
                .word      (front_words[i])
            );

            deq_cell #(
                .DEPTH      (DEPTH),
                .DATA_WIDTH (DATA_WIDTH),
                .IDX        (i)
            ) u_back_cell (
                .clk       (clk),
                .cmd       (ctl.back_cmd),
                .count     (count),
                .new_word  (new_word),
                .prev_word (b_prev),
                .next_word (b_next),
                .word      (back_words[i])
            );
        end
    endgenerate

    generate
        if (DATA_WIDTH >= WORD_W)
        begin : g_out_wide
            assign front_w = front_words[0][WORD_W-1:0];
            assign back_w  = back_words[0][WORD_W-1:0];
        end
        else
        begin : g_out_narrow
            assign front_w = {{(WORD_W-DATA_WIDTH){front_words[0][DATA_WIDTH-1]}},
                              front_words[0]};
            assign back_w  = {{(WORD_W-DATA_WIDTH){back_words[0][DATA_WIDTH-1]}},
                              back_words[0]};
        end
    endgenerate

    generate
        if (CNT_W >= deq_pkg::COUNT_W)
        begin : g_cnt_wide
            assign rsp.count = count[deq_pkg::COUNT_W-1:0];
        end
        else
        begin : g_cnt_narrow
            assign rsp.count = {{(deq_pkg::COUNT_W-CNT_W){1'b0}}, count};
        end
    endgenerate

    assign empty           = (count == '0);
    assign rsp.valid       = out_valid_reg;
    assign rsp.empty_res   = empty;
    assign rsp.front_value = empty ? '0 : front_w;
    assign rsp.back_value  = empty ? '0 : back_w;
    assign rsp.status      = status;

endmodule

/* src/deq_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic [deq_pkg::WORD_W-1:0]          front_value,
    input  logic [deq_pkg::WORD_W-1:0]          back_value,
    input  logic                                empty_res,
    input  logic [deq_pkg::STATUS_W-1:0]        status
);

    logic rsp_stall;

    assign rsp_stall = rsp_valid && !rsp_ready;

    `DEQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid)
    `DEQ_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_stall, $stable(front_value) && $stable(back_value))
    `DEQ_ASSERT_NOW(a_empty_zero, clk, rst_n, rsp_valid && empty_res, front_value == '0 && back_value == '0)
    `DEQ_ASSERT_NOW(a_underflow_empty, clk, rst_n, rsp_valid && status == deq_pkg::ST_UNDERFLOW, empty_res)
    `DEQ_ASSERT_NOW(a_overflow_nonempty, clk, rst_n, rsp_valid && status == deq_pkg::ST_OVERFLOW, !empty_res)

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .front_value (rsp.front_value),
    .back_value  (rsp.back_value),
    .empty_res   (rsp.empty_res),
    .status      (rsp.status)
);

/* dv/double_ended_queue_tb.sv */
`timescale 1ns / 1ps

module double_ended_queue_tb;
    import deq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RAND_WORDS  = 1450;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [WORD_W-1:0]   front_word;
        logic [WORD_W-1:0]   back_word;
        logic [COUNT_W-1:0]  count;
        logic                empty;
        status_t             status;
    } deq_result_t;

    typedef struct {
        op_t               op;
        logic [WORD_W-1:0] value;
        int                reps;
        bit                typed;
        deq_result_t       res;
    } stim_row_t;

    // Rows with typed set carry their own expectation; value steps by one per repeat.
    stim_row_t dir_rows [12] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ST_UNDERFLOW}},
        '{OP_POP_BACK,   32'h0000_0000, 1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ST_UNDERFLOW}},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1, 1'b1,
          '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, ST_OK}},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 5'd2, 1'b0, ST_OK}},
        '{OP_POP_BACK,   32'h0000_0000, 1, 1'b0, '0},
        '{OP_POP_FRONT,  32'hFFFF_FFFF, 1, 1'b1, '{32'h0, 32'h0, 5'd0, 1'b1, ST_OK}},
        '{OP_PUSH_FRONT, 32'h0000_0001, 8, 1'b0, '0},
        '{OP_PUSH_BACK,  32'hFFFF_FFF0, 8, 1'b0, '0},
        '{OP_PUSH_BACK,  32'h5A5A_5A5A, 1, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 1, 1'b0, '0},
        '{OP_POP_BACK,   32'h0000_0000, 1, 1'b0, '0},
        '{OP_PUSH_FRONT, 32'h0000_0000, 1, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow model of the queue, kept as a ring buffer
    logic [WORD_W-1:0]  shadow_slots [DEPTH];
    logic [3:0]         shadow_head;
    logic [3:0]         shadow_tail;
    logic [COUNT_W-1:0] shadow_count;

    deq_result_t pending_results [$];
    bit          row_typed;
    deq_result_t row_result;
    int          mismatch_count;
    int          cycle_count;
    int          burst_left;
    int          sink_mode;
    int          sink_left;
    int          sink_tick;
    bit          filling;

    function automatic deq_result_t deque_apply(op_t op, logic [WORD_W-1:0] value);
        deq_result_t r;
        r.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (shadow_count == COUNT_W'(DEPTH))
                begin
                    r.status = ST_OVERFLOW;
                end
                else if (op == OP_PUSH_FRONT)
                begin
                    shadow_head = shadow_head - 4'd1;
                    shadow_slots[shadow_head] = value;
                    shadow_count = shadow_count + 1'b1;
                end
                else
                begin
                    shadow_slots[shadow_tail] = value;
                    shadow_tail = shadow_tail + 4'd1;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            default:
            begin
                if (shadow_count == '0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else if (op == OP_POP_FRONT)
                begin
                    shadow_head = shadow_head + 4'd1;
                    shadow_count = shadow_count - 1'b1;
                end
                else
                begin
                    shadow_tail = shadow_tail - 4'd1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
        endcase
        r.count = shadow_count;
        r.empty = (shadow_count == '0);
        r.front_word = r.empty ? '0 : shadow_slots[shadow_head];
        r.back_word  = r.empty ? '0 : shadow_slots[shadow_tail - 4'd1];
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return WORD_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_val,
                                 input logic [WORD_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
        end
    endtask

    // Called at a falling edge; returns at a falling edge once the word is taken.
    task automatic send_word(input op_t op, input logic [WORD_W-1:0] value, input bit typed,
                             input deq_result_t res);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= value;
        row_typed    <= typed;
        row_result   <= res;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
    endtask

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Word accepted: advance the shadow state and queue what should come back
    always @(posedge clk)
    begin
        deq_result_t r;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            r = deque_apply(op_t'(req_ch.op), req_ch.value);
            pending_results.push_back(row_typed ? row_result : r);
        end
    end

    always @(posedge clk)
    begin
        deq_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with nothing expected: front %h back %h count %0d",
                         $time, rsp_ch.front_value, rsp_ch.back_value, rsp_ch.count);
            end
            else
            begin
                e = pending_results.pop_front();
                compare_field("front_value", e.front_word, rsp_ch.front_value);
                compare_field("back_value", e.back_word, rsp_ch.back_value);
                compare_field("count", WORD_W'(e.count), WORD_W'(rsp_ch.count));
                compare_field("empty_res", WORD_W'(e.empty), WORD_W'(rsp_ch.empty_res));
                compare_field("status", WORD_W'(e.status), WORD_W'(rsp_ch.status));
            end
        end
    end

    // Result side stalls on its own: free-running, random, sparse strobes, rare gaps
    always @(negedge clk)
    begin
        sink_tick++;
        if (sink_left <= 0)
        begin
            sink_mode = $urandom_range(0, 3);
            sink_left = $urandom_range(10, 60);
        end
        sink_left--;
        case (sink_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ch.ready <= (sink_tick % 4 == 0);
            default: rsp_ch.ready <= (sink_tick % 8 != 3);
        endcase
    end

    initial
    begin
        op_t op;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_PUSH_FRONT;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        row_typed      = 1'b0;
        row_result     = '0;
        shadow_head    = '0;
        shadow_tail    = '0;
        shadow_count   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 20;
        sink_mode      = 0;
        sink_left      = 0;
        sink_tick      = 0;
        filling        = 1'b1;
        foreach (shadow_slots[i])
            shadow_slots[i] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            for (int r = 0; r < dir_rows[i].reps; r++)
                send_word(dir_rows[i].op, dir_rows[i].value + WORD_W'(r), dir_rows[i].typed,
                          dir_rows[i].res);
        end

        // Swing between empty and full so wrap, overflow and underflow all recur
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (shadow_count == COUNT_W'(DEPTH) && $urandom_range(0, 1) == 1)
                filling = 1'b0;
            else if (shadow_count == '0 && $urandom_range(0, 1) == 1)
                filling = 1'b1;
            if ($urandom_range(0, 19) == 0)
                op = op_t'($urandom_range(0, 3));
            else if ($urandom_range(0, 9) < (filling ? 7 : 3))
                op = ($urandom_range(0, 1) == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            else
                op = ($urandom_range(0, 1) == 1) ? OP_POP_FRONT : OP_POP_BACK;
            send_word(op, pick_value(), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
